/* sv/ppc_pkg.sv */
// Shared types, constants and codes for the perspective project and clip block.
// No dependencies; every other file but ppc_if refers to this package by scoped names.
package ppc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CW = 64;           // width of a transformed component
  localparam int PW = 96;           // width of the scaled dividend
  localparam int QW = 32;           // quotient bits produced by the divider
  localparam int DIV_STAGES = QW + 1;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [30:0] HALF_W_RST = 31'd41943040;
  localparam logic [30:0] HALF_H_RST = 31'd23592960;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_NEAR = 2'd1,
    OP_WPOS = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic {
    CFG_HALF_W = 1'b0,
    CFG_HALF_H = 1'b1
  } cfg_idx_t;

  // One queued item: either a matrix load or a projection.
  typedef struct packed {
    logic        is_load;
    logic        near_mode;
    logic [3:0]  index;
    logic [31:0] value;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } item_t;

  typedef struct packed {
    logic [30:0] half_w;
    logic [30:0] half_h;
  } viewport_t;

endpackage

/* sv/ppc_if.sv */
// Handshake channel interfaces for the perspective project and clip block.
// Depends on nothing but the types of plain logic vectors.
interface ppc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [3:0]  entry_index;
  logic signed [31:0] entry_value;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  modport source (output valid, opcode, entry_index, entry_value, point_x, point_y, point_z,
                  input ready);
  modport sink (input valid, opcode, entry_index, entry_value, point_x, point_y, point_z,
                output ready);
endinterface

interface ppc_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic        xy_visible;
  modport source (output valid, accepted, screen_x, screen_y, xy_visible, input ready);
  modport sink (input valid, accepted, screen_x, screen_y, xy_visible, output ready);
endinterface

interface ppc_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* sv/ppc_fifo.sv */
// Small first-in first-out queue of items between front and back.
// Depends on ppc_pkg for the item type and depth.
module ppc_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ppc_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output ppc_pkg::item_t head
);
  localparam int AW = $clog2(ppc_pkg::QUEUE_DEPTH);

  ppc_pkg::item_t entries [ppc_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full      = (count == (AW+1)'(ppc_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue read while empty");

endmodule

/* sv/ppc_front.sv */
// Front end: accepts items, drops unused opcodes and queues the rest.
// Depends on ppc_pkg, ppc_if and ppc_fifo.
module ppc_front (
  input  logic           clk,
  input  logic           rst,
  ppc_in_if.sink         req,
  input  logic           pop,
  output logic           not_empty,
  output ppc_pkg::item_t head
);
  ppc_pkg::item_t item;
  ppc_pkg::op_t   op;
  logic           full;
  logic           push;

  assign op        = ppc_pkg::op_t'(req.opcode);
  assign req.ready = !full;
  assign push      = req.valid && !full && (op != ppc_pkg::OP_NONE);

  always_comb begin
    item.is_load   = (op == ppc_pkg::OP_LOAD);
    item.near_mode = (op == ppc_pkg::OP_NEAR);
    item.index     = req.entry_index;
    item.value     = req.entry_value;
    item.px        = req.point_x;
    item.py        = req.point_y;
    item.pz        = req.point_z;
  end

  ppc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

endmodule

/* sv/ppc_div.sv */
// Pipelined restoring divider: one quotient bit per stage, then saturation.
// Depends on ppc_pkg for widths.
module ppc_div (
  input  logic                    clk,
  input  logic                    en,
  input  logic [ppc_pkg::PW-1:0]  dividend,
  input  logic [ppc_pkg::CW-1:0]  divisor,
  input  logic                    neg,
  output logic [31:0]             result
);
  localparam int N = ppc_pkg::QW;
  localparam int CW = ppc_pkg::CW;

  logic [CW-1:0] rem   [N+1];
  logic [N-1:0]  low   [N+1];
  logic [N-1:0]  quo   [N+1];
  logic [CW-1:0] dvs   [N+1];
  logic          sgn   [N+1];
  logic          big   [N+1];

  // Stage zero: the upper bits start the remainder; a quotient beyond 32 bits is flagged.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= dividend[ppc_pkg::PW-1:N];
      low[0] <= dividend[N-1:0];
      quo[0] <= '0;
      dvs[0] <= divisor;
      sgn[0] <= neg;
      big[0] <= (dividend[ppc_pkg::PW-1:N] >= divisor);
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_stage
    logic [CW:0] trial;
    logic        ge;
    assign trial = {rem[k-1], low[k-1][N-1]};
    assign ge    = (trial >= {1'b0, dvs[k-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? CW'(trial - {1'b0, dvs[k-1]}) : trial[CW-1:0];
        low[k] <= {low[k-1][N-2:0], 1'b0};
        quo[k] <= {quo[k-1][N-2:0], ge};
        dvs[k] <= dvs[k-1];
        sgn[k] <= sgn[k-1];
        big[k] <= big[k-1];
      end
    end
  end

  always_comb begin
    if (!sgn[N]) begin
      result = (big[N] || quo[N] > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[N];
    end else begin
      result = (big[N] || quo[N] > 32'h8000_0000) ? 32'h8000_0000 : (32'd0 - quo[N]);
    end
  end

endmodule

/* sv/ppc_back.sv */
// Back end: matrix storage, transform, clip test, scaling and division pipeline.
// Depends on ppc_pkg, ppc_if and ppc_div.
module ppc_back #(
  parameter int FRAC_BITS = ppc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ppc_pkg::viewport_t vp,
  input  logic               head_valid,
  input  ppc_pkg::item_t     head,
  output logic               pop,
  ppc_out_if.source          rsp
);
  localparam int CW = ppc_pkg::CW;
  localparam int DS = ppc_pkg::DIV_STAGES;

  logic en;
  logic [31:0] mat [16];

  // stage 1: products
  logic               s1_valid, s1_near;
  logic signed [CW-1:0] s1_prod [12];
  logic signed [31:0]   s1_off  [4];
  // stage 2: components
  logic               s2_valid, s2_near;
  logic signed [CW-1:0] s2_c [4];
  // stage 3: clip and magnitudes
  logic               s3_valid, s3_acc, s3_vis, s3_neg0, s3_neg1;
  logic [CW-1:0]      s3_a0, s3_a1, s3_d;
  // stage 4: partial products
  logic               s4_valid, s4_acc, s4_vis, s4_neg0, s4_neg1;
  logic [CW-1:0]      s4_lo0, s4_hi0, s4_lo1, s4_hi1, s4_d;
  // stage 5: dividends
  logic               s5_valid, s5_acc, s5_vis, s5_neg0, s5_neg1;
  logic [ppc_pkg::PW-1:0] s5_p0, s5_p1;
  logic [CW-1:0]      s5_d;
  // divider side band
  logic [DS-1:0]      dv_valid, dv_acc, dv_vis;
  logic [31:0]        q0, q1;

  assign en  = !rsp.valid || rsp.ready;
  assign pop = en && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) mat[i] <= '0;
    end else if (pop && head.is_load) begin
      mat[head.index] <= head.value;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        s1_prod[r*3+0] <= $signed(mat[r*4+0]) * $signed(head.px);
        s1_prod[r*3+1] <= $signed(mat[r*4+1]) * $signed(head.py);
        s1_prod[r*3+2] <= $signed(mat[r*4+2]) * $signed(head.pz);
        s1_off[r]      <= $signed(mat[r*4+3]);
      end
      s1_near <= head.near_mode;
      for (int r = 0; r < 4; r++) begin
        s2_c[r] <= CW'(s1_off[r]) + (s1_prod[r*3+0] >>> FRAC_BITS)
                 + (s1_prod[r*3+1] >>> FRAC_BITS) + (s1_prod[r*3+2] >>> FRAC_BITS);
      end
      s2_near <= s1_near;
    end
  end

  logic signed [CW-1:0] t0, t1, w;
  logic acc3, vis3;
  always_comb begin
    w  = s2_c[3];
    t0 = s2_c[0] + w;
    t1 = s2_c[1] + w;
    if (s2_near) begin
      acc3 = (s2_c[2] > -w) && (w != '0);
      vis3 = (s2_c[0] >= -w) && (s2_c[0] <= w) && (s2_c[1] >= -w) && (s2_c[1] <= w);
    end else begin
      acc3 = (w > 0);
      vis3 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_acc  <= acc3;
      s3_vis  <= acc3 && vis3;
      s3_a0   <= t0[CW-1] ? -t0 : t0;
      s3_a1   <= t1[CW-1] ? -t1 : t1;
      s3_d    <= w[CW-1] ? -w : w;
      s3_neg0 <= (t0[CW-1] != w[CW-1]) && (t0 != '0);
      s3_neg1 <= (t1[CW-1] != w[CW-1]) && (t1 != '0);

      // 32 by 31 bit partial products of the magnitudes and the half sizes
      s4_lo0  <= CW'(s3_a0[31:0]  * vp.half_w);
      s4_hi0  <= CW'(s3_a0[63:32] * vp.half_w);
      s4_lo1  <= CW'(s3_a1[31:0]  * vp.half_h);
      s4_hi1  <= CW'(s3_a1[63:32] * vp.half_h);
      s4_d    <= s3_d;
      s4_acc  <= s3_acc;
      s4_vis  <= s3_vis;
      s4_neg0 <= s3_neg0;
      s4_neg1 <= s3_neg1;

      s5_p0   <= {32'd0, s4_lo0} + {s4_hi0, 32'd0};
      s5_p1   <= {32'd0, s4_lo1} + {s4_hi1, 32'd0};
      s5_d    <= s4_d;
      s5_acc  <= s4_acc;
      s5_vis  <= s4_vis;
      s5_neg0 <= s4_neg0;
      s5_neg1 <= s4_neg1;

      dv_acc  <= {dv_acc[DS-2:0], s5_acc};
      dv_vis  <= {dv_vis[DS-2:0], s5_vis};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      dv_valid <= '0;
      rsp.valid <= 1'b0;
    end else if (en) begin
      s1_valid <= pop && !head.is_load;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      dv_valid <= {dv_valid[DS-2:0], s5_valid};
      rsp.valid <= dv_valid[DS-1];
    end
  end

  ppc_div u_div_x (
    .clk(clk), .en(en), .dividend(s5_p0), .divisor(s5_d), .neg(s5_neg0), .result(q0)
  );
  ppc_div u_div_y (
    .clk(clk), .en(en), .dividend(s5_p1), .divisor(s5_d), .neg(s5_neg1), .result(q1)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      rsp.accepted   <= dv_acc[DS-1];
      rsp.xy_visible <= dv_vis[DS-1];
      rsp.screen_x   <= dv_acc[DS-1] ? q0 : '0;
      rsp.screen_y   <= dv_acc[DS-1] ? q1 : '0;
    end
  end

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
      (rsp.valid && !rsp.accepted) |-> (rsp.screen_x == '0 && rsp.screen_y == '0))
    else $error("rejected item carries a screen position");
  a_vis_needs_acc: assert property (@(posedge clk) disable iff (rst)
      (rsp.valid && rsp.xy_visible) |-> rsp.accepted)
    else $error("visible flag on a rejected item");
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
      (rsp.valid && !rsp.ready) |=>
      (rsp.valid && $stable(rsp.screen_x) && $stable(rsp.screen_y)))
    else $error("waiting result changed before it was taken");

endmodule

/* sv/perspective_project_clip_core.sv */
// An accepted item passes five transform and scaling stages, 33 divider stages and
// the result register. Throughput: one item per cycle while no result waits unread;
// the fully pipelined divider sets this figure. Reset clears the matrix to zero,
// the viewport half sizes to 640 by 360 pixels and all valid flags.
// Load items and the unused opcode give no result; every projection gives exactly one.
module perspective_project_clip_core #(
  parameter int FRAC_BITS = ppc_pkg::FRAC_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  ppc_in_if.sink   req,
  ppc_out_if.source rsp,
  ppc_cfg_if.sink  cfg
);
  // The front accepts an item whenever the queue has room and sorts out the
  // unused opcode. The back pops one item per cycle while its result register
  // is free or being read, so the two sides stall independently.

  ppc_pkg::viewport_t vp;
  ppc_pkg::item_t     head;
  logic               head_valid;
  logic               pop;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp.half_w <= ppc_pkg::HALF_W_RST;
      vp.half_h <= ppc_pkg::HALF_H_RST;
    end else if (cfg.valid) begin
      unique case (ppc_pkg::cfg_idx_t'(cfg.index))
        ppc_pkg::CFG_HALF_W: vp.half_w <= cfg.data[30:0];
        ppc_pkg::CFG_HALF_H: vp.half_h <= cfg.data[30:0];
        default: ;
      endcase
    end
  end

  ppc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .pop       (pop),
    .not_empty (head_valid),
    .head      (head)
  );

  // The back applies matrix loads in queue order, so a projection always
  // sees every load that was accepted before it.
  ppc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .vp         (vp),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rsp        (rsp)
  );

endmodule
